/* rtl/gpe_pkg.sv */
// Shared types, register codes and the 5x7 glyph ROM for the glyph pixel emitter.
// No dependencies; every other file of the block imports this package.
package gpe_pkg;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_CELLS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int COL_OFF_BITS = 10;   // holds 4 * 255
    localparam int ROW_OFF_BITS = 11;   // holds 6 * 255
    localparam int ADV_BITS     = 11;   // holds 6 * 255
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_MARGIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_SCALE = 2'd1;

    localparam logic [15:0] LEFT_MARGIN_RESET = 16'd18;
    localparam logic [7:0]  PIXEL_SCALE_RESET = 8'd3;

    localparam logic [2:0] LAST_COL = 3'd4;
    localparam logic [2:0] LAST_ROW = 3'd6;

    typedef struct packed {
        logic load;     // take a new character into the datapath
        logic step;     // scan one glyph cell
    } gpe_cmd_t;

    typedef struct packed {
        logic out_free; // output register can take a square this cycle
        logic scan_end; // the current cell is the last one of the glyph
    } gpe_stat_t;

    // Returns the glyph as 35 bits, row 0 column 0 in the top bit, then left to right
    // and top to bottom. Lower case folds onto upper case; unknown codes get a '?'.
    function automatic logic [GLYPH_CELLS-1:0] glyph_bits(input logic [7:0] code);
        logic [7:0]             up;
        logic [GLYPH_CELLS-1:0] g;
        up = ((code >= "a") && (code <= "z")) ? code - 8'd32 : code;
        unique case (up)
            "0": g = {5'h1F, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h1F};
            "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": g = {5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "4": g = {5'h12, 5'h12, 5'h12, 5'h1F, 5'h02, 5'h02, 5'h02};
            "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            "6": g = {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E};
            "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C": g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            "D": g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G": g = {5'h0F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0F};
            "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            "X": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
            ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            ",": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04, 5'h08};
            "-": g = {5'h00, 5'h00, 5'h00, 5'h1E, 5'h00, 5'h00, 5'h00};
            "+": g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            "/": g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            " ": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            default: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04, 5'h00};
        endcase
        return g;
    endfunction

endpackage

/* rtl/gpe_ctrl.sv */
// Controller of the glyph pixel emitter: idle/scan state machine.
// Depends on gpe_pkg for the command and status structs.
module gpe_ctrl
    import gpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gpe_stat_t stat,
    output gpe_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign in_ready = ready_reg;

    always_comb
    begin
        cmd.load = in_valid && ready_reg;
        cmd.step = (state_reg == ST_SCAN) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= ST_SCAN;
                        ready_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (cmd.step && stat.scan_end)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* rtl/gpe_datapath.sv */
// Datapath of the glyph pixel emitter: configuration registers, cursor, cell scan
// and the output register. Depends on gpe_pkg for the glyph ROM and shared types.
module gpe_datapath
    import gpe_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic [7:0]              char_code,
    input  logic                    first_of_line,
    input  logic [15:0]             line_y,
    input  gpe_cmd_t                cmd,
    output gpe_stat_t               stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             square_x,
    output logic [15:0]             square_y,
    output logic                    last_of_char
);

    localparam int SUM_BITS = COORD_BITS + 2;
    localparam logic [COORD_BITS-1:0] MAXC = {COORD_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   MAXC_W = {2'b00, MAXC};

    logic [15:0]             left_margin_reg;
    logic [7:0]              pixel_scale_reg;
    logic [COORD_BITS-1:0]   cursor_reg;
    logic [COORD_BITS-1:0]   base_x_reg;
    logic [COORD_BITS-1:0]   ly_reg;
    logic [GLYPH_CELLS-1:0]  mask_reg;
    logic [2:0]              col_reg;
    logic [2:0]              row_reg;
    logic [COL_OFF_BITS-1:0] col_off_reg;
    logic [ROW_OFF_BITS-1:0] row_off_reg;
    logic                    out_valid_reg;
    logic [COORD_BITS-1:0]   sq_x_reg;
    logic [COORD_BITS-1:0]   sq_y_reg;
    logic                    last_reg;

    logic [COORD_BITS-1:0] margin_clamped;
    logic [COORD_BITS-1:0] ly_clamped;
    logic [COORD_BITS-1:0] base_x_next;
    logic [ADV_BITS-1:0]   advance;
    logic [SUM_BITS-1:0]   cursor_sum;
    logic [COORD_BITS-1:0] cursor_next;
    logic [SUM_BITS-1:0]   x_sum;
    logic [SUM_BITS-1:0]   y_sum;
    logic                  cell_lit;
    logic                  emit;

    // Inputs wider than the coordinate space saturate at its top.
    assign margin_clamped = (left_margin_reg > 16'(MAXC)) ? MAXC
                                                          : COORD_BITS'(left_margin_reg);
    assign ly_clamped     = (line_y > 16'(MAXC)) ? MAXC : COORD_BITS'(line_y);
    assign base_x_next    = first_of_line ? margin_clamped : cursor_reg;

    // Six cells of advance: scale * 4 + scale * 2.
    assign advance     = {1'b0, pixel_scale_reg, 2'b00} + {2'b00, pixel_scale_reg, 1'b0};
    assign cursor_sum  = SUM_BITS'(base_x_next) + SUM_BITS'(advance);
    assign cursor_next = (cursor_sum > MAXC_W) ? MAXC : COORD_BITS'(cursor_sum);

    assign x_sum    = SUM_BITS'(base_x_reg) + SUM_BITS'(col_off_reg);
    assign y_sum    = SUM_BITS'(ly_reg) + SUM_BITS'(row_off_reg);
    assign cell_lit = mask_reg[GLYPH_CELLS-1];
    assign emit     = cmd.step && cell_lit;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.scan_end = (col_reg == LAST_COL) && (row_reg == LAST_ROW);

    assign out_valid    = out_valid_reg;
    assign square_x     = 16'(sq_x_reg);
    assign square_y     = 16'(sq_y_reg);
    assign last_of_char = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_margin_reg <= LEFT_MARGIN_RESET;
            pixel_scale_reg <= PIXEL_SCALE_RESET;
            cursor_reg      <= COORD_BITS'(LEFT_MARGIN_RESET);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LEFT_MARGIN)
                begin
                    left_margin_reg <= cfg_data;
                end
                else if (cfg_index == CFG_PIXEL_SCALE)
                begin
                    pixel_scale_reg <= cfg_data[7:0];
                end
            end
            if (cmd.load)
            begin
                cursor_reg <= cursor_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_x_reg  <= base_x_next;
            ly_reg      <= ly_clamped;
            mask_reg    <= glyph_bits(char_code);
            col_reg     <= '0;
            row_reg     <= '0;
            col_off_reg <= '0;
            row_off_reg <= '0;
        end
        else if (cmd.step)
        begin
            mask_reg <= {mask_reg[GLYPH_CELLS-2:0], 1'b0};
            if (col_reg == LAST_COL)
            begin
                col_reg     <= '0;
                col_off_reg <= '0;
                row_reg     <= row_reg + 3'd1;
                row_off_reg <= row_off_reg + ROW_OFF_BITS'(pixel_scale_reg);
            end
            else
            begin
                col_reg     <= col_reg + 3'd1;
                col_off_reg <= col_off_reg + COL_OFF_BITS'(pixel_scale_reg);
            end
        end
        if (emit)
        begin
            sq_x_reg <= (x_sum > MAXC_W) ? MAXC : COORD_BITS'(x_sum);
            sq_y_reg <= (y_sum > MAXC_W) ? MAXC : COORD_BITS'(y_sum);
            last_reg <= ~|mask_reg[GLYPH_CELLS-2:0];
        end
    end

endmodule

/* rtl/glyph_pixel_emitter_5x7.sv */
// Top level of the 5x7 glyph pixel emitter: stream ports, configuration port.
// Instantiates gpe_ctrl and gpe_datapath; depends on gpe_pkg.

// Each input transaction carries one character; the block looks it up in a built-in
// 5x7 font (lower case folds to upper case, unknown codes draw a question mark) and
// sends one output transaction per lit cell, scanned top row first and left to right,
// holding the top-left corner of a pixel_scale by pixel_scale square. The last square
// of a character has tlast set; a blank character sends nothing. After a character is
// accepted, all 35 cells of the glyph are scanned, one cell a cycle whether lit or not
// while the output register is free; a waiting square that is held back stalls the scan
// and so stretches the character. The input is ready again right after the last cell
// is scanned while the final square may still wait to be taken. Coordinates saturate
// at 2^COORD_BITS - 1. The cursor advances by six cells per character and tuser
// reloads it from left_margin.
// Configuration writes (index 0: left_margin, index 1: pixel_scale, others ignored)
// are always accepted and must only be issued while the block is idle.
module glyph_pixel_emitter_5x7
    import gpe_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data,
    // Character stream.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // char_code[7:0], line_y[23:8]
    input  logic                    s_tuser,   // first_of_line
    // Square stream.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // square_x[15:0], square_y[31:16]
    output logic                    m_tlast    // last_of_char
);

    gpe_cmd_t    cmd;
    gpe_stat_t   stat;
    logic [15:0] square_x;
    logic [15:0] square_y;

    // Registers are plain flops, so writes never stall.
    assign cfg_ready = 1'b1;
    assign m_tdata   = {square_y, square_x};

    gpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gpe_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_code     (s_tdata[7:0]),
        .first_of_line (s_tuser),
        .line_y        (s_tdata[23:8]),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .square_x      (square_x),
        .square_y      (square_y),
        .last_of_char  (m_tlast)
    );

endmodule

/* sim/glyph_square_checker.sv */
// Checker for the 5x7 glyph pixel emitter: watches the configuration, character and
// square channels, predicts every square and compares it with what the block sends.
// Depends on gpe_pkg for the register codes, reset values and port widths.
module glyph_square_checker
    import gpe_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [23:0]             s_tdata,    // char_code[7:0], line_y[23:8]
    input  logic                    s_tuser,    // first_of_line
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [31:0]             m_tdata,    // square_x[15:0], square_y[31:16]
    input  logic                    m_tlast,    // last_of_char
    output int                      mismatches,
    output int                      outstanding
);

    localparam int unsigned COORD_MAX = (32'd1 << COORD_BITS) - 32'd1;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } square_t;

    // One entry per glyph: the character in the top byte, then rows 0..6, one byte each.
    localparam logic [63:0] FONT [0:39] = '{
        64'h30_1F_11_13_15_19_11_1F, 64'h31_04_0C_04_04_04_04_0E,
        64'h32_1E_01_01_1E_10_10_1F, 64'h33_1E_01_01_0E_01_01_1E,
        64'h34_12_12_12_1F_02_02_02, 64'h35_1F_10_10_1E_01_01_1E,
        64'h36_0F_10_10_1E_11_11_0E, 64'h37_1F_01_02_04_08_08_08,
        64'h38_0E_11_11_0E_11_11_0E, 64'h39_0E_11_11_0F_01_01_1E,
        64'h41_0E_11_11_1F_11_11_11, 64'h42_1E_11_11_1E_11_11_1E,
        64'h43_0F_10_10_10_10_10_0F, 64'h44_1E_11_11_11_11_11_1E,
        64'h45_1F_10_10_1E_10_10_1F, 64'h46_1F_10_10_1E_10_10_10,
        64'h47_0F_10_10_13_11_11_0F, 64'h48_11_11_11_1F_11_11_11,
        64'h49_1F_04_04_04_04_04_1F, 64'h4C_10_10_10_10_10_10_1F,
        64'h4D_11_1B_15_15_11_11_11, 64'h4E_11_19_15_13_11_11_11,
        64'h4F_0E_11_11_11_11_11_0E, 64'h50_1E_11_11_1E_10_10_10,
        64'h52_1E_11_11_1E_14_12_11, 64'h53_0F_10_10_0E_01_01_1E,
        64'h54_1F_04_04_04_04_04_04, 64'h55_11_11_11_11_11_11_0E,
        64'h56_11_11_11_11_11_0A_04, 64'h57_11_11_11_15_15_15_0A,
        64'h58_11_11_0A_04_0A_11_11, 64'h59_11_11_0A_04_04_04_04,
        64'h5A_1F_01_02_04_08_10_1F, 64'h3A_00_04_04_00_04_04_00,
        64'h2E_00_00_00_00_00_0C_0C, 64'h2C_00_00_00_00_04_04_08,
        64'h2D_00_00_00_1E_00_00_00, 64'h2B_00_04_04_1F_04_04_00,
        64'h2F_01_01_02_04_08_10_10, 64'h20_00_00_00_00_00_00_00
    };
    localparam logic [55:0] QUESTION_ROWS = 56'h1F_01_02_04_00_04_00;

    logic [15:0] margin;
    logic [7:0]  scale;
    logic [15:0] cursor;
    square_t     expected_squares[$];

    function automatic logic [15:0] saturate(input int unsigned v);
        return (v > COORD_MAX) ? 16'(COORD_MAX) : 16'(v);
    endfunction

    function automatic logic [55:0] glyph_rows(input logic [7:0] code);
        logic [7:0]  key;
        logic [55:0] rows;
        key  = ((code >= "a") && (code <= "z")) ? code - 8'd32 : code;
        rows = QUESTION_ROWS;
        for (int i = 0; i < 40; i++)
            if (FONT[i][63:56] == key)
                rows = FONT[i][55:0];
        return rows;
    endfunction

    // Expands one character into its squares, row by row and left to right.
    task automatic rasterize_char(input logic [7:0] code, input logic first,
                                  input logic [15:0] line_y);
        logic [55:0] rows;
        logic [7:0]  row_bits;
        logic [15:0] top;
        square_t     batch [0:34];
        int          lit;
        rows = glyph_rows(code);
        top  = saturate(line_y);
        lit  = 0;
        if (first)
            cursor = saturate(margin);
        for (int r = 0; r < 7; r++)
        begin
            row_bits = rows[55 - 8 * r -: 8];
            for (int c = 0; c < 5; c++)
            begin
                if (row_bits[4 - c])
                begin
                    batch[lit].x    = saturate(cursor + c * scale);
                    batch[lit].y    = saturate(top + r * scale);
                    batch[lit].last = 1'b0;
                    lit++;
                end
            end
        end
        if (lit > 0)
            batch[lit - 1].last = 1'b1;
        for (int i = 0; i < lit; i++)
            expected_squares.insert(expected_squares.size(), batch[i]);
        cursor = saturate(cursor + 6 * scale);
    endtask

    task automatic flag(input string what, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic check_square(input logic [15:0] x, input logic [15:0] y,
                                input logic last);
        square_t want;
        if (expected_squares.size() == 0)
        begin
            $display("%0t: unexpected square, expected none, actual (%0d, %0d) last %0d",
                     $time, x, y, last);
            mismatches++;
        end
        else
        begin
            want = expected_squares.pop_front();
            if (want.x !== x)
                flag("square_x", want.x, x);
            if (want.y !== y)
                flag("square_y", want.y, y);
            if (want.last !== last)
                flag("last_of_char", want.last, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin      = LEFT_MARGIN_RESET;
            scale       = PIXEL_SCALE_RESET;
            cursor      = saturate(LEFT_MARGIN_RESET);
            expected_squares.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // A square can never belong to a character taken at the same edge.
            if (m_tvalid && m_tready)
                check_square(m_tdata[15:0], m_tdata[31:16], m_tlast);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEFT_MARGIN)
                    margin = cfg_data;
                else if (cfg_index == CFG_PIXEL_SCALE)
                    scale = cfg_data[7:0];
            end
            if (s_tvalid && s_tready)
                rasterize_char(s_tdata[7:0], s_tuser, s_tdata[23:8]);
            outstanding = expected_squares.size();
        end
    end

endmodule

/* sim/tb_glyph_pixel_emitter_5x7.sv */
// Testbench top for the 5x7 glyph pixel emitter: clock, reset, character and
// configuration stimulus, square stream back-pressure and the final verdict.
// Depends on gpe_pkg, the block itself and glyph_square_checker.
module tb_glyph_pixel_emitter_5x7;
    import gpe_pkg::*;

    localparam int COORD_BITS   = 16;
    localparam int RANDOM_CHARS = 450;
    localparam int PHASES       = 6;
    // The scan walks all 35 cells even after the last lit one has gone out, so the
    // block is not yet idle when the last square has gone out.
    localparam int DRAIN_CYCLES = 48;
    localparam int END_WAIT     = 20000;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [15:0]             cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [23:0]             s_tdata;   // char_code[7:0], line_y[23:8]
    logic                    s_tuser;   // first_of_line
    logic                    m_tvalid;
    logic                    m_tready;
    logic [31:0]             m_tdata;   // square_x[15:0], square_y[31:16]
    logic                    m_tlast;   // last_of_char

    int mismatches;
    int outstanding;
    int chars_sent;
    // While set, neither side inserts gaps, so characters run back to back.
    bit no_gaps;

    glyph_pixel_emitter_5x7 #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    glyph_square_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always #5 clk = ~clk;

    // Safety net: far beyond the slowest correct run, where every character would send
    // 35 squares and each square would wait out the longest stall.
    initial
    begin
        #20_000_000;
        $display("tb_glyph_pixel_emitter_5x7: errors");
        $finish;
    end

    // Square stream back-pressure. Before each square the receiver holds tready low for
    // a random stall, then keeps it high until a transaction completes.
    // A zero stall leaves tready high, so back-to-back squares go through.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Sends one character. It is entered at a falling edge and returns at the falling
    // edge after the transaction, with tvalid still high; the next call lowers it only
    // when it draws a gap, so tvalid never drops and rises within one time step.
    task automatic send_char(input logic [7:0] code, input logic first,
                             input logic [15:0] line_y);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {line_y, code};
        s_tuser  = first;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        chars_sent++;
    endtask

    // Stops the character stream and waits until the block has gone quiet, so that a
    // register write cannot land in the middle of a character.
    task automatic settle();
        s_tvalid = 1'b0;
        no_gaps  = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes one register; cfg_valid stays high so consecutive writes need no toggle.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index, input logic [15:0] data);
        cfg_index = index;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Loads both registers and also writes an index with no register behind it, which
    // must leave the settings untouched. Only the low byte of the scale word counts.
    task automatic set_config(input logic [15:0] margin, input logic [15:0] scale_word);
        write_reg(CFG_LEFT_MARGIN, margin);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom));
        write_reg(CFG_PIXEL_SCALE, scale_word);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 8'("0" + $urandom_range(0, 9));
        else if (r < 55)
            return 8'("A" + $urandom_range(0, 25));
        else if (r < 80)
            return 8'("a" + $urandom_range(0, 25));
        case ($urandom_range(0, 7))
            0: return ":";
            1: return ".";
            2: return ",";
            3: return "-";
            4: return "+";
            5: return "/";
            6: return " ";
            default: return "?";
        endcase
    endfunction

    function automatic logic [15:0] pick_line_y();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'($urandom_range(0, 16'h0400));
        else if (r < 7)
            return 16'($urandom_range(16'hFF00, 16'hFFFF));
        return 16'($urandom);
    endfunction

    // One line of text: the first character reloads the cursor and the rest follow on
    // the same baseline. Some lines skip the reload, and a few characters are pure
    // noise with random code, flag and line.
    task automatic type_line();
        int          len;
        bit          broken;
        logic [15:0] line_y;
        len     = $urandom_range(1, 12);
        broken  = ($urandom_range(0, 9) == 0);
        line_y  = pick_line_y();
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(8'($urandom), 1'($urandom), 16'($urandom));
            else
                send_char(pick_text_char(), (i == 0) && !broken, line_y);
        end
    endtask

    initial
    begin
        int waited;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_LEFT_MARGIN;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        no_gaps    = 1'b0;
        chars_sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings: digits and letters, case folding,
        // letters missing from the font, the blank space, high and control codes that
        // fall back to the question mark, and lines at the top of the coordinate
        // range where the y of the lower squares saturates.
        send_char("0", 1'b1, 16'd0);
        send_char("A", 1'b0, 16'd0);
        send_char("a", 1'b0, 16'd0);
        send_char("z", 1'b0, 16'd0);
        send_char("J", 1'b0, 16'd0);
        send_char("q", 1'b0, 16'd0);
        send_char(" ", 1'b0, 16'd0);
        send_char(8'h00, 1'b0, 16'd0);
        send_char(8'hFF, 1'b0, 16'd40);
        send_char(8'h80, 1'b0, 16'd40);
        send_char("?", 1'b0, 16'd40);
        send_char("W", 1'b0, 16'hFFFF);
        send_char(".", 1'b1, 16'hFFF0);
        send_char(":", 1'b0, 16'hFFF0);
        send_char(",", 1'b0, 16'hFFF0);
        settle();

        // Largest margin and scale: every x saturates and the cursor pins at the top.
        set_config(16'hFFFF, 16'h00FF);
        send_char("8", 1'b1, 16'd1000);
        send_char("/", 1'b0, 16'd1000);
        send_char("-", 1'b0, 16'd1000);
        settle();

        // Zero scale with junk in the upper byte: all squares of a character collapse
        // onto the cursor and the cursor stays where it is.
        set_config(16'h0000, 16'hA500);
        send_char("M", 1'b1, 16'd0);
        send_char("+", 1'b0, 16'd7);
        send_char("E", 1'b0, 16'hFFFF);
        settle();

        // Random part, in phases with different settings. The extremes come back here
        // with random text on top of them.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_config(16'($urandom_range(0, 2000)), 16'h0001);
                1: set_config(16'($urandom), 16'($urandom_range(1, 255)) | 16'($urandom) << 8);
                2: set_config(16'h0000, 16'h00FF);
                3: set_config(16'hFFFF, 16'($urandom_range(1, 8)));
                4: set_config(16'($urandom_range(0, 1000)), {8'($urandom), 8'h00});
                default: set_config(16'($urandom), 16'($urandom_range(2, 6)));
            endcase
            while (chars_sent < 21 + (phase + 1) * RANDOM_CHARS / PHASES)
                type_line();
            settle();
        end

        // Everything has been sent; give the last squares time to come out, bounded so
        // that a lost square shows up as a leftover expectation rather than a hang.
        s_tvalid = 1'b0;
        waited   = 0;
        while ((outstanding != 0) && (waited < END_WAIT))
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if ((mismatches == 0) && (outstanding == 0))
            $display("tb_glyph_pixel_emitter_5x7: clean");
        else
            $display("tb_glyph_pixel_emitter_5x7: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/gpe_pkg.sv
rtl/gpe_ctrl.sv
rtl/gpe_datapath.sv
rtl/glyph_pixel_emitter_5x7.sv
sim/glyph_square_checker.sv
sim/tb_glyph_pixel_emitter_5x7.sv
